// ----- design/skt_pkg.sv -----
// Package for the sorted key table: sizes, codes, controller states and
// the command struct between controller and datapath. No dependencies.
package skt_pkg;
	localparam int Depth = 64;
	localparam int IdxW = $clog2(Depth);
	localparam int CntW = IdxW + 1;
	localparam logic [31:0] TimeoutReset = 32'd1000;

	typedef enum logic [1:0] {
		CMD_SEARCH  = 2'd0,
		CMD_ADD     = 2'd1,
		CMD_REMOVE  = 2'd2,
		CMD_SPECIAL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_COLLIDE  = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_PICK,
		S_EXEC,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture the input item
		logic compare;  // register per-entry compare vectors
		logic pick;     // priority pick over the compare vectors
		logic exec;     // apply shift / stamp clear, form the result
	} dp_cmd_t;
endpackage

// ----- design/sorted_key_table_with_timed_lookup.sv -----
// Top level of the sorted key table with timed lookup: stream ports, timeout
// register, controller and datapath. Depends on skt_pkg, skt_ctrl, skt_datapath.
//
// channel | direction | fields
// s_axis  | in        | tdata: command, key, hash, thread_id, stamp, now_tick,
//         |           |        by_position, position
// m_axis  | out       | tdata: status, found, index, entry_count
// cfg     | in        | timeout_ticks
//
// Each item is handled in steps: the accept edge captures it, then compare in all
// cells, priority pick, and execute with shift into the result register.
// The result is offered once execute has written the result register.
// A new item is accepted in the cycle its predecessor's result is taken.
// Reset clears the entry count and sets the timeout to 1000.
// A stalled result holds all state until m_axis_tready rises.
module sorted_key_table_with_timed_lookup (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command[1:0], key[65:2], hash[97:66], thread_id[129:98], stamp[161:130],
	// now_tick[193:162], by_position[194], position[200:195], zero fill
	input  logic [207:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0], found[2], index[9:3], entry_count[16:10], zero fill
	output logic [23:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);
	import skt_pkg::*;

	logic [31:0] timeout_q;
	dp_cmd_t     cmd;
	logic        in_fire, out_fire;
	logic [1:0]  r_status;
	logic        r_found;
	logic [6:0]  r_index, r_count;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// hold timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TimeoutReset;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	skt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_fire (out_fire),
		.in_rdy   (s_axis_tready),
		.out_vld  (m_axis_tvalid),
		.cmd      (cmd)
	);

	skt_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.timeout    (timeout_q),
		.in_command (s_axis_tdata[1:0]),
		.in_key     (s_axis_tdata[65:2]),
		.in_hash    (s_axis_tdata[97:66]),
		.in_tid     (s_axis_tdata[129:98]),
		.in_stamp   (s_axis_tdata[161:130]),
		.in_now     (s_axis_tdata[193:162]),
		.in_bypos   (s_axis_tdata[194]),
		.in_pos     (s_axis_tdata[200:195]),
		.res_status (r_status),
		.res_found  (r_found),
		.res_index  (r_index),
		.res_count  (r_count)
	);

	assign m_axis_tdata = {7'd0, r_count, r_index, r_found, r_status};
endmodule

// ----- design/skt_ctrl.sv -----
// Controller of the sorted key table: sequences load, compare, pick and
// execute, and runs the output handshake. Depends on skt_pkg.
module skt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               out_fire,
	output logic               in_rdy,
	output logic               out_vld,
	output skt_pkg::dp_cmd_t   cmd
);
	import skt_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_rdy = 1'b0;
		out_vld = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_rdy = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				state_d = S_PICK;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_vld = 1'b1;
				in_rdy = out_fire;
				if (out_fire) begin
					if (in_fire) begin
						cmd.load = 1'b1;
						state_d = S_CMP;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ----- design/skt_datapath.sv -----
// Datapath of the sorted key table: entry cells with parallel compare and
// shift, priority pick, stamp age check and result register. Depends on skt_pkg.
module skt_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  skt_pkg::dp_cmd_t        cmd,
	input  logic [31:0]             timeout,
	input  logic [1:0]              in_command,
	input  logic [63:0]             in_key,
	input  logic [31:0]             in_hash,
	input  logic [31:0]             in_tid,
	input  logic [31:0]             in_stamp,
	input  logic [31:0]             in_now,
	input  logic                    in_bypos,
	input  logic [5:0]              in_pos,
	output logic [1:0]              res_status,
	output logic                    res_found,
	output logic [6:0]              res_index,
	output logic [6:0]              res_count
);
	import skt_pkg::*;

	logic [63:0] key_q [Depth];
	logic [31:0] hash_q [Depth];
	logic [31:0] own_q [Depth];
	logic [31:0] stmp_q [Depth];
	logic [CntW-1:0] count_q;

	logic [1:0]  c_cmd_q;
	logic [63:0] c_key_q;
	logic [31:0] c_hash_q, c_tid_q, c_stamp_q, c_now_q;
	logic        c_bypos_q;
	logic [5:0]  c_pos_q;

	logic [Depth-1:0] eq_s1, lt_s1, hm_s1;
	logic             hit_s2, hhit_s2;
	logic [IdxW-1:0]  hit_idx_s2, hidx_s2;
	logic [CntW-1:0]  ins_s2;
	logic [31:0]      hstamp_s2;

	// capture input item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_cmd_q <= in_command;
			c_key_q <= in_key;
			c_hash_q <= in_hash;
			c_tid_q <= in_tid;
			c_stamp_q <= in_stamp;
			c_now_q <= in_now;
			c_bypos_q <= in_bypos;
			c_pos_q <= in_pos;
		end
	end

	// compare all live cells at once
	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int i = 0; i < Depth; i++) begin
				eq_s1[i] <= (CntW'(i) < count_q) && key_q[i] == c_key_q;
				lt_s1[i] <= (CntW'(i) < count_q) && key_q[i] < c_key_q;
				hm_s1[i] <= (CntW'(i) < count_q) && hash_q[i] == c_hash_q
					&& own_q[i] == c_tid_q;
			end
		end
	end

	// priority pick: match index, insertion point (first cell not below the
	// key), first hash/owner match
	logic            hit_c, hhit_c;
	logic [IdxW-1:0] hit_idx_c, hidx_c;
	logic [CntW-1:0] ins_c;
	always_comb begin
		hit_c = 1'b0;
		hhit_c = 1'b0;
		hit_idx_c = '0;
		hidx_c = '0;
		ins_c = CntW'(Depth);
		for (int i = Depth - 1; i >= 0; i--) begin
			if (eq_s1[i]) begin
				hit_c = 1'b1;
				hit_idx_c = IdxW'(i);
			end
			if (hm_s1[i]) begin
				hhit_c = 1'b1;
				hidx_c = IdxW'(i);
			end
			if (!lt_s1[i]) begin
				ins_c = CntW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			hit_s2 <= hit_c;
			hit_idx_s2 <= hit_idx_c;
			ins_s2 <= ins_c;
			hhit_s2 <= hhit_c;
			hidx_s2 <= hidx_c;
			hstamp_s2 <= stmp_q[hidx_c];
		end
	end

	// execute decision
	logic [31:0] diff_c, mag_c;
	logic        do_ins, do_del, do_clr;
	logic [IdxW-1:0] at_c;
	logic [1:0]  st_c;
	logic        fnd_c;
	logic [6:0]  idx_c;
	logic [CntW-1:0] pos_ext;
	always_comb begin
		diff_c = c_now_q - hstamp_s2;
		mag_c = diff_c[31] ? (32'd0 - diff_c) : diff_c;
		pos_ext = CntW'(c_pos_q);
		do_ins = 1'b0;
		do_del = 1'b0;
		do_clr = 1'b0;
		at_c = hit_idx_s2;
		st_c = ST_NOTFOUND;
		fnd_c = 1'b0;
		idx_c = 7'(ins_s2);
		case (c_cmd_q)
			CMD_SEARCH: begin
				if (hit_s2) begin
					st_c = ST_OK;
					fnd_c = 1'b1;
					idx_c = 7'(hit_idx_s2);
				end
			end
			CMD_ADD: begin
				if (hit_s2) begin
					st_c = ST_COLLIDE;
					idx_c = 7'(hit_idx_s2);
				end else if (count_q >= CntW'(Depth)) begin
					st_c = ST_FULL;
				end else begin
					st_c = ST_OK;
					do_ins = 1'b1;
					at_c = IdxW'(ins_s2);
				end
			end
			CMD_REMOVE: begin
				if (c_bypos_q) begin
					idx_c = 7'(c_pos_q);
					if (pos_ext < count_q) begin
						st_c = ST_OK;
						do_del = 1'b1;
						at_c = IdxW'(c_pos_q);
					end
				end else if (hit_s2) begin
					st_c = ST_OK;
					do_del = 1'b1;
					idx_c = 7'(hit_idx_s2);
				end
			end
			default: begin
				idx_c = '0;
				at_c = hidx_s2;
				if (hhit_s2 && hstamp_s2 != 32'd0) begin
					if (mag_c < timeout) begin
						st_c = ST_OK;
						fnd_c = 1'b1;
						idx_c = 7'(hidx_s2);
					end else begin
						do_clr = 1'b1;
					end
				end
			end
		endcase
	end

	// cell shift / insert / clear
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < Depth; i++) begin
				if (do_ins && IdxW'(i) == at_c) begin
					key_q[i] <= c_key_q;
					hash_q[i] <= c_hash_q;
					own_q[i] <= c_tid_q;
					stmp_q[i] <= c_stamp_q;
				end else if (do_ins && IdxW'(i) > at_c && i > 0) begin
					key_q[i] <= key_q[i-1];
					hash_q[i] <= hash_q[i-1];
					own_q[i] <= own_q[i-1];
					stmp_q[i] <= stmp_q[i-1];
				end else if (do_del && IdxW'(i) >= at_c && i < Depth - 1) begin
					key_q[i] <= key_q[i+1];
					hash_q[i] <= hash_q[i+1];
					own_q[i] <= own_q[i+1];
					stmp_q[i] <= stmp_q[i+1];
				end else if (do_clr && IdxW'(i) == at_c) begin
					stmp_q[i] <= '0;
				end
			end
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (do_ins) count_q <= count_q + 1'b1;
			else if (do_del) count_q <= count_q - 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status <= st_c;
			res_found <= fnd_c;
			res_index <= idx_c;
			res_count <= 7'(do_ins ? count_q + 1'b1 : (do_del ? count_q - 1'b1 : count_q));
		end
	end
endmodule

// ----- tb/tb.sv -----
// Self-checking bench for the sorted key table with timed lookup: drives items,
// predicts each result from a shadow table and compares on the master stream.
// Depends on skt_pkg and sorted_key_table_with_timed_lookup.
`timescale 1ns / 1ps

module tb;
	import skt_pkg::*;

	typedef struct {
		cmd_t        command;
		logic [63:0] key;
		logic [31:0] hash;
		logic [31:0] thread_id;
		logic [31:0] stamp;
		logic [31:0] now_tick;
		logic        by_position;
		logic [5:0]  position;
	} op_t;

	typedef struct {
		status_t    status;
		logic       found;
		logic [6:0] index;
		logic [6:0] entry_count;
	} reply_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [207:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [23:0]  m_axis_tdata;
	logic         cfg_we;
	logic [31:0]  cfg_wdata;

	sorted_key_table_with_timed_lookup uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// shadow table
	logic [63:0] sh_key [Depth];
	logic [31:0] sh_hash [Depth];
	logic [31:0] sh_owner [Depth];
	logic [31:0] sh_stamp [Depth];
	int          sh_count;
	logic [31:0] sh_timeout;

	op_t    pending_ops[$];
	reply_t expected_replies[$];
	int     errors;
	int     send_idle_pct;
	int     recv_stall_pct;
	longint cycles;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic report(input string what);
		errors++;
		$display("error at cycle %0d: %s", cycles, what);
	endtask

	function automatic bit find_key(input logic [63:0] k, output int where);
		int lo, hi, mid;
		lo = 0;
		hi = sh_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (sh_key[mid] == k) begin
				where = mid;
				return 1'b1;
			end
			if (k > sh_key[mid]) lo = mid + 1;
			else hi = mid;
		end
		where = lo;
		return 1'b0;
	endfunction

	function automatic void drop_entry(input int p);
		for (int i = p; i < sh_count - 1; i++) begin
			sh_key[i] = sh_key[i + 1];
			sh_hash[i] = sh_hash[i + 1];
			sh_owner[i] = sh_owner[i + 1];
			sh_stamp[i] = sh_stamp[i + 1];
		end
		sh_count--;
	endfunction

	// compute the result of one item and update the shadow table
	function automatic reply_t apply_op(input op_t op);
		reply_t r;
		int p;
		logic [31:0] d;
		r.status = ST_NOTFOUND;
		r.found = 1'b0;
		r.index = '0;
		p = 0;
		case (op.command)
			CMD_SEARCH: begin
				if (find_key(op.key, p)) begin
					r.status = ST_OK;
					r.found = 1'b1;
				end
				r.index = p[6:0];
			end
			CMD_ADD: begin
				if (find_key(op.key, p)) r.status = ST_COLLIDE;
				else if (sh_count >= Depth) r.status = ST_FULL;
				else begin
					for (int i = sh_count; i > p; i--) begin
						sh_key[i] = sh_key[i - 1];
						sh_hash[i] = sh_hash[i - 1];
						sh_owner[i] = sh_owner[i - 1];
						sh_stamp[i] = sh_stamp[i - 1];
					end
					sh_key[p] = op.key;
					sh_hash[p] = op.hash;
					sh_owner[p] = op.thread_id;
					sh_stamp[p] = op.stamp;
					sh_count++;
					r.status = ST_OK;
				end
				r.index = p[6:0];
			end
			CMD_REMOVE: begin
				if (op.by_position) begin
					p = op.position;
					if (p < sh_count) begin
						drop_entry(p);
						r.status = ST_OK;
					end
				end else if (find_key(op.key, p)) begin
					drop_entry(p);
					r.status = ST_OK;
				end
				r.index = p[6:0];
			end
			default: begin
				for (int i = 0; i < sh_count; i++) begin
					if (sh_hash[i] == op.hash && sh_owner[i] == op.thread_id) begin
						if (sh_stamp[i] != 0) begin
							d = op.now_tick - sh_stamp[i];
							if (d[31]) d = -d;
							if (d < sh_timeout) begin
								r.status = ST_OK;
								r.found = 1'b1;
								r.index = i[6:0];
							end else sh_stamp[i] = '0;
						end
						break;
					end
				end
			end
		endcase
		r.entry_count = sh_count[6:0];
		return r;
	endfunction

	function automatic logic [207:0] pack_op(input op_t op);
		logic [207:0] v;
		v = '0;
		v[1:0] = op.command;
		v[65:2] = op.key;
		v[97:66] = op.hash;
		v[129:98] = op.thread_id;
		v[161:130] = op.stamp;
		v[193:162] = op.now_tick;
		v[194] = op.by_position;
		v[200:195] = op.position;
		return v;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// random item; keys and hashes drawn from small pools so hits are common
	function automatic op_t rand_op();
		op_t op;
		op.command = cmd_t'($urandom_range(3));
		if ($urandom_range(9) == 0) op.key = rand64();
		else if ($urandom_range(3) == 0) op.key = 64'hFFFF_FFFF_FFFF_FFF0 + $urandom_range(15);
		else op.key = 64'($urandom_range(90));
		if ($urandom_range(7) == 0) begin
			op.hash = $urandom();
			op.thread_id = $urandom();
		end else begin
			op.hash = 32'hC000_0000 | $urandom_range(7);
			op.thread_id = 32'h8000_0000 | $urandom_range(3);
		end
		case ($urandom_range(5))
			0: op.stamp = '0;
			1: op.stamp = $urandom();
			default: op.stamp = 32'h7FFF_FF00 + $urandom_range(511);
		endcase
		op.now_tick = ($urandom_range(3) == 0) ? $urandom() : 32'h7FFF_FF00 + $urandom_range(2047);
		op.by_position = 1'($urandom_range(1));
		op.position = 6'($urandom_range(63));
		return op;
	endfunction

	function automatic op_t make_op(input cmd_t c, input logic [63:0] k, input logic [31:0] h,
			input logic [31:0] t, input logic [31:0] s, input logic [31:0] n,
			input logic bp, input logic [5:0] pos);
		op_t op;
		op.command = c;
		op.key = k;
		op.hash = h;
		op.thread_id = t;
		op.stamp = s;
		op.now_tick = n;
		op.by_position = bp;
		op.position = pos;
		return op;
	endfunction

	// drive items from the pending queue; predict at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_replies.push_back(apply_op(pending_ops.pop_front()));
			end
			if ((!s_axis_tvalid || s_axis_tready)) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pack_op(pending_ops[0]);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// take results and compare against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_replies.size() == 0) begin
					report($sformatf("unexpected result %h", m_axis_tdata));
				end else begin
					want = expected_replies.pop_front();
					if (m_axis_tdata[1:0] !== want.status)
						report($sformatf("status %0d, want %0d", m_axis_tdata[1:0], want.status));
					if (m_axis_tdata[2] !== want.found)
						report($sformatf("found %b, want %b", m_axis_tdata[2], want.found));
					if (m_axis_tdata[9:3] !== want.index)
						report($sformatf("index %0d, want %0d", m_axis_tdata[9:3], want.index));
					if (m_axis_tdata[16:10] !== want.entry_count)
						report($sformatf("entry_count %0d, want %0d", m_axis_tdata[16:10],
							want.entry_count));
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("sorted_key_table_with_timed_lookup: mismatch");
			$finish;
		end
	end

	// let the queue run dry and all results arrive
	task automatic drain();
		while (pending_ops.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_timeout = v;
	endtask

	task automatic random_phase(input int n, input int idle, input int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) pending_ops.push_back(rand_op());
		drain();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		sh_count = 0;
		sh_timeout = TimeoutReset;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, collision, stamps, removes
		pending_ops.push_back(make_op(CMD_SEARCH, '1, '1, '1, '1, '1, 1'b1, '1));
		pending_ops.push_back(make_op(CMD_REMOVE, 64'd5, 0, 0, 0, 0, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_REMOVE, 0, 0, 0, 0, 0, 1'b1, 6'd0));
		pending_ops.push_back(make_op(CMD_SPECIAL, 0, 32'h1, 32'h2, 0, 0, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_ADD, '1, '1, '1, '1, '1, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_ADD, '0, 32'h1, 32'h2, 32'd100, 0, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_ADD, 64'd50, 32'h1, 32'h3, 32'd5, 0, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_ADD, 64'd50, 0, 0, 0, 0, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_ADD, 64'd60, 32'h7, 32'h7, 32'h0, 0, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_SEARCH, 64'd50, 0, 0, 0, 0, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_SEARCH, 64'd55, 0, 0, 0, 0, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_SPECIAL, 0, 32'h1, 32'h3, 0, 32'd1004, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_SPECIAL, 0, 32'h1, 32'h3, 0, 32'd1005, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_SPECIAL, 0, 32'h1, 32'h3, 0, 32'd1004, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_SPECIAL, 0, 32'h7, 32'h7, 0, 0, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_SPECIAL, 0, '1, '1, 0, 32'h7FFF_FFFF, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_SPECIAL, 0, 32'h1, 32'h2, 0, 32'h8000_0064, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_REMOVE, 0, 0, 0, 0, 0, 1'b1, 6'd63));
		pending_ops.push_back(make_op(CMD_REMOVE, 0, 0, 0, 0, 0, 1'b1, 6'd1));
		pending_ops.push_back(make_op(CMD_REMOVE, '1, 0, 0, 0, 0, 1'b0, 0));
		drain();

		// wrap-around difference with widest timeout
		write_timeout('1);
		pending_ops.push_back(make_op(CMD_ADD, 64'd9, 32'h5, 32'h5, 32'h8000_0000, 0, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_SPECIAL, 0, 32'h5, 32'h5, 0, 32'h0, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_SPECIAL, 0, 32'h5, 32'h5, 0, 32'hFFFF_FFFF, 1'b0, 0));
		drain();

		// fill to full, then empty again
		send_idle_pct = 0;
		for (int i = 0; i < 70; i++)
			pending_ops.push_back(make_op(CMD_ADD, rand64(), $urandom(), $urandom(),
				$urandom(), 0, 1'b0, 0));
		pending_ops.push_back(make_op(CMD_ADD, 64'd1, 0, 0, 0, 0, 1'b0, 0));
		for (int i = 0; i < 66; i++)
			pending_ops.push_back(make_op(CMD_REMOVE, 0, 0, 0, 0, 0, 1'b1, 6'($urandom_range(63))));
		for (int i = 0; i < 66; i++)
			pending_ops.push_back(make_op(CMD_REMOVE, 0, 0, 0, 0, 0, 1'b1, 6'd0));
		drain();

		write_timeout(32'd0);
		random_phase(300, 0, 0);
		write_timeout(32'd300);
		random_phase(400, 82, 0);
		write_timeout(32'd1000);
		random_phase(400, 0, 82);
		write_timeout(32'h8000_0000);
		random_phase(350, 38, 38);
		write_timeout(32'd1);
		random_phase(200, 0, 0);

		if (errors == 0) begin
			$display("sorted_key_table_with_timed_lookup: match");
		end else begin
			$display("sorted_key_table_with_timed_lookup: mismatch");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
design/skt_pkg.sv
design/skt_ctrl.sv
design/skt_datapath.sv
design/sorted_key_table_with_timed_lookup.sv
tb/tb.sv
